FILE: src/ps2s1_pkg.sv
// Package for the PS/2 set 1 scan code decoder.
// Holds the prefix state type, the held-key record and the scan code constants.
// No dependencies.
package ps2s1_pkg;

   localparam int ScanWidth = 8;
   localparam int KeyWidth  = 7;

   localparam logic [ScanWidth-1:0] SC_PREFIX_E0   = 8'hE0;
   localparam logic [ScanWidth-1:0] SC_PREFIX_E1   = 8'hE1;
   localparam logic [ScanWidth-1:0] SC_FAKE_MAKE   = 8'h2A;
   localparam logic [ScanWidth-1:0] SC_FAKE_BREAK  = 8'hAA;

   localparam logic [KeyWidth-1:0] KEY_LSHIFT   = 7'h2A;
   localparam logic [KeyWidth-1:0] KEY_RSHIFT   = 7'h36;
   localparam logic [KeyWidth-1:0] KEY_CTRL     = 7'h1D;
   localparam logic [KeyWidth-1:0] KEY_ALT      = 7'h38;
   localparam logic [KeyWidth-1:0] KEY_NUMLOCK  = 7'h45;
   localparam logic [KeyWidth-1:0] KEY_CAPSLOCK = 7'h3A;
   localparam logic [KeyWidth-1:0] KEY_DELETE   = 7'h53;

   typedef enum logic [3:0] {
      PFX_NONE = 4'b0001,
      PFX_E0   = 4'b0010,
      PFX_E1_A = 4'b0100,
      PFX_E1_B = 4'b1000
   } prefix_type;

   // Only the keys that feed the modifier mask and the reboot check are kept.
   typedef struct packed {
      logic lshift;
      logic rshift;
      logic alt;
      logic alt_ext;
      logic ctrl;
      logic ctrl_ext;
   } held_type;

endpackage

FILE: src/ps2_set1_scancode_decoder.sv
// Top level of the PS/2 scan code set 1 decoder.
// Depends on ps2s1_pkg for the prefix state type and the scan code constants.
//
// Each accepted byte on the req_ channel yields exactly one beat on the rsp_
// channel. A byte enters an input register, is decoded against the prefix
// state, the held-key bits and the lock flags, and its result is written to
// the output register once that register is free or being read, so a new
// byte can be taken in every cycle while the rsp_ channel does not stall. Both registers move
// on when the next stage can take their contents, so a stalled result does not
// stop the input register from filling. Of the press map only the shift, Alt
// and Ctrl bits are stored, since no other key's held state feeds the outputs.
module ps2_set1_scancode_decoder
   import ps2s1_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ScanWidth-1:0] req_scancode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_event_valid,
   output logic                 rsp_extended,
   output logic [KeyWidth-1:0]  rsp_key_code,
   output logic                 rsp_pressed,
   output logic                 rsp_num_lock,
   output logic                 rsp_caps_lock,
   output logic                 rsp_led_update,
   output logic [2:0]           rsp_led_value,
   output logic                 rsp_reboot_request,
   output logic [2:0]           rsp_modifiers
);

   logic                 in_valid_ff;
   logic [ScanWidth-1:0] scan_ff;
   logic                 out_valid_ff;
   prefix_type           prefix_ff, prefix_in;
   held_type             held_ff, held_in;
   logic                 num_lock_ff, num_lock_in;
   logic                 caps_lock_ff, caps_lock_in;

   logic                 event_valid_ff, event_in;
   logic                 extended_ff, extended_in;
   logic [KeyWidth-1:0]  key_code_ff, key_code_in;
   logic                 pressed_ff, pressed_in;
   logic                 led_update_ff, led_update_in;
   logic                 reboot_ff, reboot_in;
   logic [2:0]           modifiers_ff, modifiers_in;

   logic                 advance;
   logic [KeyWidth-1:0]  code;
   logic                 make;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign code      = scan_ff[KeyWidth-1:0];
   assign make      = !scan_ff[ScanWidth-1];

   always_comb begin
      prefix_in     = prefix_ff;
      event_in      = 1'b0;
      extended_in   = 1'b0;
      held_in       = held_ff;
      num_lock_in   = num_lock_ff;
      caps_lock_in  = caps_lock_ff;
      led_update_in = 1'b0;
      reboot_in     = 1'b0;

      case (prefix_ff)
         PFX_E1_B: begin
            prefix_in = PFX_NONE;
         end
         PFX_E1_A: begin
            prefix_in = PFX_E1_B;
         end
         PFX_E0: begin
            prefix_in = PFX_NONE;
            if (!(scan_ff inside {SC_FAKE_MAKE, SC_FAKE_BREAK})) begin
               event_in    = 1'b1;
               extended_in = 1'b1;
            end
         end
         PFX_NONE: begin
            if (scan_ff == SC_PREFIX_E0) begin
               prefix_in = PFX_E0;
            end else if (scan_ff == SC_PREFIX_E1) begin
               prefix_in = PFX_E1_A;
            end else begin
               event_in = 1'b1;
            end
         end
         default: begin
            prefix_in = PFX_NONE;
         end
      endcase

      if (event_in) begin
         if (extended_in) begin
            if (code == KEY_ALT) held_in.alt_ext = make;
            if (code == KEY_CTRL) held_in.ctrl_ext = make;
            reboot_in = make && (code == KEY_DELETE) && held_ff.ctrl && held_ff.alt;
         end else begin
            if (code == KEY_LSHIFT) held_in.lshift = make;
            if (code == KEY_RSHIFT) held_in.rshift = make;
            if (code == KEY_ALT) held_in.alt = make;
            if (code == KEY_CTRL) held_in.ctrl = make;
            if (make && code == KEY_NUMLOCK) begin
               num_lock_in   = !num_lock_ff;
               led_update_in = 1'b1;
            end
            if (make && code == KEY_CAPSLOCK) begin
               caps_lock_in  = !caps_lock_ff;
               led_update_in = 1'b1;
            end
         end
      end

      key_code_in  = event_in ? code : '0;
      pressed_in   = event_in && make;
      modifiers_in = {held_in.ctrl || held_in.ctrl_ext,
                      held_in.alt || held_in.alt_ext,
                      held_in.lshift || held_in.rshift};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prefix_ff    <= PFX_NONE;
         held_ff      <= '0;
         num_lock_ff  <= 1'b0;
         caps_lock_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            prefix_ff    <= prefix_in;
            held_ff      <= held_in;
            num_lock_ff  <= num_lock_in;
            caps_lock_ff <= caps_lock_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         scan_ff <= req_scancode;
      end
      if (advance) begin
         event_valid_ff <= event_in;
         extended_ff    <= extended_in;
         key_code_ff    <= key_code_in;
         pressed_ff     <= pressed_in;
         led_update_ff  <= led_update_in;
         reboot_ff      <= reboot_in;
         modifiers_ff   <= modifiers_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_valid    = event_valid_ff;
   assign rsp_extended       = extended_ff;
   assign rsp_key_code       = key_code_ff;
   assign rsp_pressed        = pressed_ff;
   assign rsp_num_lock       = num_lock_ff;
   assign rsp_caps_lock      = caps_lock_ff;
   assign rsp_led_update     = led_update_ff;
   assign rsp_led_value      = {caps_lock_ff, num_lock_ff, 1'b0};
   assign rsp_reboot_request = reboot_ff;
   assign rsp_modifiers      = modifiers_ff;

endmodule

FILE: test/ps2_set1_scancode_decoder_tb.sv
// Testbench for ps2_set1_scancode_decoder: directed and random set-1 byte streams with
// random gaps and stalls on both channels, checked against a built-in decoder model.
// Depends on ps2s1_pkg and the decoder RTL.
module ps2_set1_scancode_decoder_tb;
   import ps2s1_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 500000;
   localparam int MaxGap     = 17;

   typedef struct {
      logic                event_valid;
      logic                extended;
      logic [KeyWidth-1:0] key_code;
      logic                pressed;
      logic                num_lock;
      logic                caps_lock;
      logic                led_update;
      logic [2:0]          led_value;
      logic                reboot_request;
      logic [2:0]          modifiers;
   } key_event_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ScanWidth-1:0] req_scancode = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_event_valid;
   logic                 rsp_extended;
   logic [KeyWidth-1:0]  rsp_key_code;
   logic                 rsp_pressed;
   logic                 rsp_num_lock;
   logic                 rsp_caps_lock;
   logic                 rsp_led_update;
   logic [2:0]           rsp_led_value;
   logic                 rsp_reboot_request;
   logic [2:0]           rsp_modifiers;

   prefix_type   prefix_seen = PFX_NONE;
   logic [127:0] plain_held  = '0;
   logic [127:0] ext_held    = '0;
   logic         num_on      = 1'b0;
   logic         caps_on     = 1'b0;

   key_event_type expected_events[$];
   int         error_count   = 0;
   int         items_sent    = 0;
   int         cycle_count   = 0;
   int         hold_request  = 0;
   bit         sender_burst  = 1'b0;
   bit         receiver_burst = 1'b0;

   ps2_set1_scancode_decoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_scancode       (req_scancode),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_extended       (rsp_extended),
      .rsp_key_code       (rsp_key_code),
      .rsp_pressed        (rsp_pressed),
      .rsp_num_lock       (rsp_num_lock),
      .rsp_caps_lock      (rsp_caps_lock),
      .rsp_led_update     (rsp_led_update),
      .rsp_led_value      (rsp_led_value),
      .rsp_reboot_request (rsp_reboot_request),
      .rsp_modifiers      (rsp_modifiers)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic key_event_type decode_scancode(input logic [ScanWidth-1:0] sc);
      key_event_type ev;
      ev.event_valid    = 1'b0;
      ev.extended       = 1'b0;
      ev.key_code       = sc[KeyWidth-1:0];
      ev.pressed        = ~sc[7];
      ev.led_update     = 1'b0;
      ev.reboot_request = 1'b0;
      case (prefix_seen)
         PFX_E1_B: begin
            prefix_seen = PFX_NONE;
         end
         PFX_E1_A: begin
            prefix_seen = PFX_E1_B;
         end
         PFX_E0: begin
            prefix_seen = PFX_NONE;
            if (sc != SC_FAKE_MAKE && sc != SC_FAKE_BREAK) begin
               ev.event_valid = 1'b1;
               ev.extended    = 1'b1;
            end
         end
         default: begin
            if (sc == SC_PREFIX_E0) prefix_seen = PFX_E0;
            else if (sc == SC_PREFIX_E1) prefix_seen = PFX_E1_A;
            else ev.event_valid = 1'b1;
         end
      endcase
      if (ev.event_valid) begin
         if (ev.extended) ext_held[ev.key_code] = ev.pressed;
         else plain_held[ev.key_code] = ev.pressed;
         if (ev.pressed) begin
            if (ev.extended && ev.key_code == KEY_DELETE) begin
               ev.reboot_request = plain_held[KEY_CTRL] & plain_held[KEY_ALT];
            end else if (!ev.extended && ev.key_code == KEY_NUMLOCK) begin
               num_on        = ~num_on;
               ev.led_update = 1'b1;
            end else if (!ev.extended && ev.key_code == KEY_CAPSLOCK) begin
               caps_on       = ~caps_on;
               ev.led_update = 1'b1;
            end
         end
      end else begin
         ev.key_code = '0;
         ev.pressed  = 1'b0;
      end
      ev.num_lock  = num_on;
      ev.caps_lock = caps_on;
      ev.led_value = {caps_on, num_on, 1'b0};
      ev.modifiers = {plain_held[KEY_CTRL] | ext_held[KEY_CTRL],
                      plain_held[KEY_ALT] | ext_held[KEY_ALT],
                      plain_held[KEY_LSHIFT] | plain_held[KEY_RSHIFT]};
      return ev;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= 10)
            $display("Mismatch on %s at cycle %0d: expected %0h, got %0h",
                     field, cycle_count, want, got);
      end
   endtask

   always @(posedge clock) begin
      key_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Unexpected result beat at cycle %0d", cycle_count);
         end else begin
            want = expected_events.pop_front();
            compare_field("event_valid", 32'(want.event_valid), 32'(rsp_event_valid));
            compare_field("extended", 32'(want.extended), 32'(rsp_extended));
            compare_field("key_code", 32'(want.key_code), 32'(rsp_key_code));
            compare_field("pressed", 32'(want.pressed), 32'(rsp_pressed));
            compare_field("num_lock", 32'(want.num_lock), 32'(rsp_num_lock));
            compare_field("caps_lock", 32'(want.caps_lock), 32'(rsp_caps_lock));
            compare_field("led_update", 32'(want.led_update), 32'(rsp_led_update));
            compare_field("led_value", 32'(want.led_value), 32'(rsp_led_value));
            compare_field("reboot_request", 32'(want.reboot_request),
                          32'(rsp_reboot_request));
            compare_field("modifiers", 32'(want.modifiers), 32'(rsp_modifiers));
         end
      end
   end

   // The receiver takes one beat per loop, after an optional long hold-off and a random gap.
   initial begin
      int gap;
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request != 0) begin
            hold         = hold_request;
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         gap = (receiver_burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_scancode(input logic [ScanWidth-1:0] sc);
      int gap;
      gap = (sender_burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_scancode <= sc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_events.push_back(decode_scancode(sc));
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
   endtask

   function automatic logic [KeyWidth-1:0] pick_key();
      case ($urandom_range(0, 13))
         0: return KEY_LSHIFT;
         1: return KEY_RSHIFT;
         2: return KEY_CTRL;
         3: return KEY_ALT;
         4: return KEY_NUMLOCK;
         5: return KEY_CAPSLOCK;
         6: return KEY_DELETE;
         default: return KeyWidth'($urandom_range(0, 127));
      endcase
   endfunction

   task automatic send_random_sequence();
      logic [KeyWidth-1:0] key;
      logic                brk;
      int                  kind;
      key  = pick_key();
      brk  = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 19);
      if (kind < 10) begin
         send_scancode({brk, key});
      end else if (kind < 15) begin
         send_scancode(SC_PREFIX_E0);
         send_scancode({brk, key});
      end else if (kind == 15) begin
         send_scancode(SC_PREFIX_E0);
         send_scancode(brk ? SC_FAKE_BREAK : SC_FAKE_MAKE);
      end else if (kind == 16) begin
         send_scancode(SC_PREFIX_E1);
         send_scancode(ScanWidth'($urandom_range(0, 255)));
         send_scancode(ScanWidth'($urandom_range(0, 255)));
      end else begin
         send_scancode(ScanWidth'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_extreme_bytes();
      send_scancode(8'h00);
      send_scancode(8'h7F);
      send_scancode(8'h80);
      send_scancode(8'hFF);
      wait_drained();
   endtask

   task automatic test_lock_keys();
      send_scancode({1'b0, KEY_NUMLOCK});
      send_scancode({1'b1, KEY_NUMLOCK});
      send_scancode({1'b0, KEY_CAPSLOCK});
      send_scancode({1'b1, KEY_CAPSLOCK});
      send_scancode(SC_PREFIX_E0);
      send_scancode({1'b0, KEY_NUMLOCK});
      wait_drained();
   endtask

   task automatic test_prefix_handling();
      send_scancode(SC_PREFIX_E0);
      send_scancode(SC_FAKE_MAKE);
      send_scancode(SC_PREFIX_E0);
      send_scancode(SC_FAKE_BREAK);
      send_scancode(SC_PREFIX_E0);
      send_scancode(SC_PREFIX_E0);
      send_scancode(SC_PREFIX_E0);
      send_scancode(SC_PREFIX_E1);
      send_scancode(SC_PREFIX_E1);
      send_scancode(8'h1D);
      send_scancode(8'h45);
      wait_drained();
   endtask

   task automatic test_ctrl_alt_del();
      send_scancode({1'b0, KEY_CTRL});
      send_scancode({1'b0, KEY_ALT});
      send_scancode(SC_PREFIX_E0);
      send_scancode({1'b0, KEY_DELETE});
      send_scancode(SC_PREFIX_E0);
      send_scancode({1'b1, KEY_DELETE});
      send_scancode({1'b1, KEY_CTRL});
      send_scancode({1'b1, KEY_ALT});
      wait_drained();
   endtask

   task automatic test_random_typing(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) send_random_sequence();
      wait_drained();
   endtask

   task automatic test_back_to_back(input int count);
      int target;
      target         = items_sent + count;
      sender_burst   = 1'b1;
      receiver_burst = 1'b1;
      while (items_sent < target) send_random_sequence();
      wait_drained();
      sender_burst   = 1'b0;
      receiver_burst = 1'b0;
   endtask

   task automatic test_receiver_stall(input int count);
      int target;
      target       = items_sent + count;
      sender_burst = 1'b1;
      hold_request = $urandom_range(200, 400);
      while (items_sent < target) send_random_sequence();
      wait_drained();
      sender_burst = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_bytes();
      test_lock_keys();
      test_prefix_handling();
      test_ctrl_alt_del();
      test_random_typing(700);
      test_back_to_back(300);
      test_receiver_stall(60);
      test_random_typing(150);
      test_receiver_stall(60);
      test_random_typing(150);
      wait_drained();
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
